>>> hdl/cbm_pkg.sv
`default_nettype none

package cbm_pkg;

  // register file geometry
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  // largest supported sizes
  localparam int unsigned MaxRomBankBits = 9;
  localparam int unsigned MaxRamAddrBits = 17;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_CART_TYPE     = 2'd0,
    REG_ROM_BANK_BITS = 2'd1,
    REG_RAM_ADDR_BITS = 2'd2
  } reg_idx_e;

  // mapper kinds
  typedef enum logic [2:0] {
    CART_NONE = 3'd0,
    CART_MBC1 = 3'd1,
    CART_MBC2 = 3'd2,
    CART_MBC3 = 3'd3,
    CART_MBC5 = 3'd4
  } cart_e;

  // result action codes
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_ROM_RD = 3'd1,
    ACT_RAM_RD = 3'd2,
    ACT_RAM_WR = 3'd3,
    ACT_OPEN   = 3'd4,
    ACT_REG_WR = 3'd5,
    ACT_DROP   = 3'd6
  } action_e;

  // one bus access
  typedef struct packed {
    logic        req_type;
    logic [15:0] bus_address;
    logic [7:0]  write_value;
  } req_t;

  // one mapping result
  typedef struct packed {
    logic [2:0]  action;
    logic [22:0] phys_address;
    logic [7:0]  mem_write_data;
    logic        force_high_nibble;
  } rsp_t;

  // configuration registers as seen by the decoder
  typedef struct packed {
    logic [2:0] cart_type;
    logic [3:0] rom_bank_bits;
    logic [4:0] ram_addr_bits;
  } cfg_t;

endpackage

`default_nettype wire

>>> hdl/cbm_cfg.sv
`default_nettype none

module cbm_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cbm_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [cbm_pkg::CfgDataW-1:0]  pwdata,
  output logic      [cbm_pkg::CfgDataW-1:0]  prdata,
  output logic                               pready,
  output cbm_pkg::cfg_t                      cfg_o
);
  import cbm_pkg::*;

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_CART_TYPE:     cfg_d.cart_type     = pwdata[2:0];
        REG_ROM_BANK_BITS: cfg_d.rom_bank_bits = pwdata[3:0];
        REG_RAM_ADDR_BITS: cfg_d.ram_addr_bits = pwdata[4:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cart_type     <= CART_NONE;
      cfg_q.rom_bank_bits <= 4'd1;
      cfg_q.ram_addr_bits <= 5'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_CART_TYPE:     prdata = {{(CfgDataW-3){1'b0}}, cfg_q.cart_type};
      REG_ROM_BANK_BITS: prdata = {{(CfgDataW-4){1'b0}}, cfg_q.rom_bank_bits};
      REG_RAM_ADDR_BITS: prdata = {{(CfgDataW-5){1'b0}}, cfg_q.ram_addr_bits};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> hdl/cbm_map.sv
`default_nettype none

module cbm_map (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cbm_pkg::cfg_t cfg_i,
  input  wire cbm_pkg::req_t req_i,
  input  wire logic          advance_i,
  output cbm_pkg::rsp_t      rsp_o
);
  import cbm_pkg::*;

  // mapper state
  logic [8:0] low_rom_bank_q, low_rom_bank_d;
  logic [1:0] high_bank_bits_q, high_bank_bits_d;
  logic [3:0] ram_sel_q, ram_sel_d;
  logic       mode_bit_q, mode_bit_d;
  logic       ram_on_q, ram_on_d;

  logic [15:0] a;
  logic [7:0]  v;
  logic        wr, is_mapper, in_ram, ram_ok, en;
  logic [3:0]  rom_b;
  logic [4:0]  ram_b;
  logic [8:0]  rom_mask;
  logic [16:0] ram_mask;
  logic [8:0]  bank_lo, bank_hi;
  logic [16:0] ram_off;
  logic [3:0]  ram_blk;

  assign a         = req_i.bus_address;
  assign v         = req_i.write_value;
  assign wr        = req_i.req_type;
  assign is_mapper = (cfg_i.cart_type == CART_MBC1) || (cfg_i.cart_type == CART_MBC2) ||
                     (cfg_i.cart_type == CART_MBC3) || (cfg_i.cart_type == CART_MBC5);
  assign in_ram    = (a[15:13] == 3'b101);
  assign ram_ok    = ram_on_q && (cfg_i.ram_addr_bits != 5'd0);
  assign en        = (v[3:0] == 4'hA);

  // size masks, clamped to the largest sizes
  assign rom_b    = (cfg_i.rom_bank_bits > 4'(MaxRomBankBits)) ? 4'(MaxRomBankBits)
                                                               : cfg_i.rom_bank_bits;
  assign ram_b    = (cfg_i.ram_addr_bits > 5'(MaxRamAddrBits)) ? 5'(MaxRamAddrBits)
                                                               : cfg_i.ram_addr_bits;
  assign rom_mask = 9'((10'd1 << rom_b) - 10'd1);
  assign ram_mask = 17'((18'd1 << ram_b) - 18'd1);

  // rom banks for the fixed and the switchable window
  assign bank_lo = (cfg_i.cart_type == CART_MBC1 && mode_bit_q)
                   ? {2'b00, high_bank_bits_q, 5'b0} : 9'd0;
  assign bank_hi = (cfg_i.cart_type == CART_MBC1)
                   ? {2'b00, high_bank_bits_q, low_rom_bank_q[4:0]} : low_rom_bank_q;

  // external ram offset
  always_comb begin
    ram_blk = (cfg_i.cart_type == CART_MBC1) ? (mode_bit_q ? {2'b00, high_bank_bits_q} : 4'd0)
                                             : ram_sel_q;
    if (cfg_i.cart_type == CART_MBC2) begin
      ram_off = {8'd0, a[8:0]} & ram_mask;
    end else begin
      ram_off = {ram_blk, a[12:0]} & ram_mask;
    end
  end

  // result decode
  always_comb begin
    rsp_o = '0;
    if (wr) begin
      if (!a[15]) begin
        rsp_o.action = is_mapper ? ACT_REG_WR : ACT_DROP;
      end else if (in_ram) begin
        if (!ram_ok) begin
          rsp_o.action = ACT_DROP;
        end else begin
          rsp_o.action         = ACT_RAM_WR;
          rsp_o.phys_address   = {6'd0, ram_off};
          rsp_o.mem_write_data = (cfg_i.cart_type == CART_MBC2) ? {4'd0, v[3:0]} : v;
        end
      end
    end else begin
      if (a[15:14] == 2'b00) begin
        rsp_o.action       = ACT_ROM_RD;
        rsp_o.phys_address = {bank_lo & rom_mask, a[13:0]};
      end else if (a[15:14] == 2'b01) begin
        rsp_o.action       = ACT_ROM_RD;
        rsp_o.phys_address = {bank_hi & rom_mask, a[13:0]};
      end else if (in_ram) begin
        if (!ram_ok) begin
          rsp_o.action = ACT_OPEN;
        end else begin
          rsp_o.action            = ACT_RAM_RD;
          rsp_o.phys_address      = {6'd0, ram_off};
          rsp_o.force_high_nibble = (cfg_i.cart_type == CART_MBC2);
        end
      end
    end
  end

  // mapper register writes
  always_comb begin
    low_rom_bank_d   = low_rom_bank_q;
    high_bank_bits_d = high_bank_bits_q;
    ram_sel_d        = ram_sel_q;
    mode_bit_d       = mode_bit_q;
    ram_on_d         = ram_on_q;
    if (advance_i && wr && !a[15]) begin
      case (cfg_i.cart_type)
        CART_MBC1: begin
          case (a[14:13])
            2'd0:    ram_on_d = en;
            2'd1:    low_rom_bank_d = (v[4:0] == 5'd0) ? 9'd1 : {4'd0, v[4:0]};
            2'd2:    high_bank_bits_d = v[1:0];
            default: mode_bit_d = v[0];
          endcase
        end
        CART_MBC2: begin
          if (!a[14]) begin
            if (a[8]) begin
              low_rom_bank_d = (v[3:0] == 4'd0) ? 9'd1 : {5'd0, v[3:0]};
            end else begin
              ram_on_d = en;
            end
          end
        end
        CART_MBC3: begin
          case (a[14:13])
            2'd0:    ram_on_d = en;
            2'd1:    low_rom_bank_d = (v[6:0] == 7'd0) ? 9'd1 : {2'd0, v[6:0]};
            2'd2:    if (v <= 8'h03) ram_sel_d = v[3:0];
            default: ;
          endcase
        end
        CART_MBC5: begin
          case (a[14:12])
            3'd0, 3'd1: ram_on_d = en;
            3'd2:       low_rom_bank_d = {low_rom_bank_q[8], v};
            3'd3:       low_rom_bank_d = {v[0], low_rom_bank_q[7:0]};
            3'd4, 3'd5: ram_sel_d = v[3:0];
            default:    ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_rom_bank_q   <= 9'd1;
      high_bank_bits_q <= 2'd0;
      ram_sel_q        <= 4'd0;
      mode_bit_q       <= 1'b0;
      ram_on_q         <= 1'b0;
    end else begin
      low_rom_bank_q   <= low_rom_bank_d;
      high_bank_bits_q <= high_bank_bits_d;
      ram_sel_q        <= ram_sel_d;
      mode_bit_q       <= mode_bit_d;
      ram_on_q         <= ram_on_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/cartridge_bank_mapper_top.sv
`default_nettype none

// Cartridge bank controller: each bus access item (read or write, 16-bit address,
// data byte) yields one result item with an action code, the physical ROM or external
// RAM byte address, the byte to store and the MBC2 high-nibble flag. Writes to the
// 0x0000-0x7FFF window update the mapper registers of the selected kind (none, MBC1,
// MBC2, MBC3, MBC5). The block takes one item per clock while its output is not stalled;
// each item passes an input register, the decode and mask logic and the result register,
// and a stalled output backs up through both registers. Mapper kind, ROM bank bits and
// RAM size are set over the APB-style port (cart_type at 0x0, rom_bank_bits at 0x4,
// ram_addr_bits at 0x8); the user must set them only while no item is in flight, as the
// block itself does not enforce this.
module cartridge_bank_mapper_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire cbm_pkg::req_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output cbm_pkg::rsp_t                      out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cbm_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [cbm_pkg::CfgDataW-1:0]  pwdata,
  output logic      [cbm_pkg::CfgDataW-1:0]  prdata,
  output logic                               pready
);
  import cbm_pkg::*;

  cfg_t cfg;
  req_t req_q;
  rsp_t rsp, rsp_q;
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free, advance, in_accept;

  // handshake between the two stages
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_data_i;
    end
    if (advance) begin
      rsp_q <= rsp;
    end
  end

  cbm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cbm_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .req_i     (req_q),
    .advance_i (advance),
    .rsp_o     (rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  // stall only while an item waits in the input register
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  // a free result register never holds the input side back
  a_no_stall_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("input stalled while result register is free");

  // a new result only comes from an item in the input register
  a_result_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_valid_q))
    else $error("result appeared without a decoded item");

endmodule

`default_nettype wire

>>> test/cartridge_bank_mapper_top_test.sv
`default_nettype none

module cartridge_bank_mapper_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cbm_pkg::*;

  localparam int unsigned CLK_PERIOD = 10;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASES = 8;
  localparam int unsigned ACCESSES_PER_PHASE = 50;
  localparam int unsigned DIR_ROWS = 35;

  // access direction
  localparam logic REQ_RD = 1'b0;
  localparam logic REQ_WR = 1'b1;
  // mapper kind outside the defined set, decodes as no mapper
  localparam logic [2:0] CART_UNKNOWN = 3'd7;
  // low nibble that turns external ram on
  localparam logic [3:0] RAM_KEY = 4'hA;

  // one row of the directed table: either new settings or one access
  typedef struct packed {
    logic is_cfg;
    cfg_t cfg;
    req_t req;
    logic has_lit;
    rsp_t lit;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic pready;

  cartridge_bank_mapper_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // mapper settings and bank registers as the predictor sees them
  logic [2:0] cfg_cart = CART_NONE;
  logic [3:0] cfg_rom_bits = 4'd1;
  logic [4:0] cfg_ram_bits = 5'd0;
  logic [8:0] bank_lo = 9'd1;
  logic [1:0] bank_hi = 2'd0;
  logic [3:0] ram_sel = 4'd0;
  logic bank_mode = 1'b0;
  logic ram_en = 1'b0;

  rsp_t pending_maps[$];
  dir_row_t directed_rows [DIR_ROWS];
  logic calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned accesses_sent = 0;
  int unsigned results_seen = 0;
  int unsigned settings_run = 0;
  int unsigned action_hits [8];
  int unsigned quiet_cycles = 0;
  int unsigned stall_run = 0;
  rsp_t obs_want, obs_got;

  function automatic dir_row_t cfg_row(logic [2:0] cart, logic [3:0] rb, logic [4:0] ra);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.cfg.cart_type = cart;
    row.cfg.rom_bank_bits = rb;
    row.cfg.ram_addr_bits = ra;
    return row;
  endfunction

  function automatic dir_row_t acc_row(logic wr, logic [15:0] a, logic [7:0] v);
    dir_row_t row;
    row = '0;
    row.req.req_type = wr;
    row.req.bus_address = a;
    row.req.write_value = v;
    return row;
  endfunction

  function automatic dir_row_t lit_row(logic wr, logic [15:0] a, logic [7:0] v,
                                       action_e act, logic [22:0] phys);
    dir_row_t row;
    row = acc_row(wr, a, v);
    row.has_lit = 1'b1;
    row.lit.action = act;
    row.lit.phys_address = phys;
    return row;
  endfunction

  // ram byte offset after banking and size wrap
  function automatic logic [22:0] ram_offset(logic [15:0] a);
    int unsigned bits, mask, bank;
    bits = (cfg_ram_bits > MaxRamAddrBits) ? MaxRamAddrBits : cfg_ram_bits;
    mask = (1 << bits) - 1;
    if (cfg_cart == CART_MBC2) begin
      return 23'((a - 16'hA000) & 32'h01FF & mask);
    end
    if (cfg_cart == CART_MBC1) begin
      bank = bank_mode ? bank_hi : 0;
    end else begin
      bank = ram_sel;
    end
    return 23'((bank * 32'h2000 + (a - 16'hA000)) & mask);
  endfunction

  // maps one access and applies its register side effects
  function automatic rsp_t map_access(req_t r);
    rsp_t res;
    logic [15:0] a;
    logic [7:0] v;
    logic is_mapper, key_ok;
    int unsigned bits, mask, bank;
    res = '0;
    a = r.bus_address;
    v = r.write_value;
    is_mapper = (cfg_cart >= CART_MBC1) && (cfg_cart <= CART_MBC5);
    key_ok = (v[3:0] == RAM_KEY);
    bits = (cfg_rom_bits > MaxRomBankBits) ? MaxRomBankBits : cfg_rom_bits;
    mask = (1 << bits) - 1;
    if (r.req_type == REQ_WR) begin
      if (a < 16'h8000) begin
        res.action = is_mapper ? ACT_REG_WR : ACT_DROP;
        case (cfg_cart)
          CART_MBC1: begin
            if (a < 16'h2000) ram_en = key_ok;
            else if (a < 16'h4000) begin
              bank_lo = {4'd0, v[4:0]};
              if (bank_lo == 0) bank_lo = 9'd1;
            end else if (a < 16'h6000) bank_hi = v[1:0];
            else bank_mode = v[0];
          end
          CART_MBC2: begin
            if (a < 16'h4000) begin
              if (a[8]) begin
                bank_lo = {5'd0, v[3:0]};
                if (bank_lo == 0) bank_lo = 9'd1;
              end else ram_en = key_ok;
            end
          end
          CART_MBC3: begin
            if (a < 16'h2000) ram_en = key_ok;
            else if (a < 16'h4000) begin
              bank_lo = {2'd0, v[6:0]};
              if (bank_lo == 0) bank_lo = 9'd1;
            end else if (a < 16'h6000) begin
              if (v <= 8'h03) ram_sel = v[3:0];
            end
          end
          CART_MBC5: begin
            if (a < 16'h2000) ram_en = key_ok;
            else if (a < 16'h3000) bank_lo = {bank_lo[8], v};
            else if (a < 16'h4000) bank_lo = {v[0], bank_lo[7:0]};
            else if (a < 16'h6000) ram_sel = v[3:0];
          end
          default: ;
        endcase
      end else if (a >= 16'hA000 && a <= 16'hBFFF) begin
        if (!ram_en || cfg_ram_bits == 0) res.action = ACT_DROP;
        else begin
          res.action = ACT_RAM_WR;
          res.phys_address = ram_offset(a);
          res.mem_write_data = (cfg_cart == CART_MBC2) ? {4'd0, v[3:0]} : v;
        end
      end
    end else begin
      if (a < 16'h4000) begin
        // fixed window, upper bits only in mbc1 mode 1
        bank = (cfg_cart == CART_MBC1 && bank_mode) ? (bank_hi << 5) : 0;
        res.action = ACT_ROM_RD;
        res.phys_address = 23'(((bank & mask) << 14) | a);
      end else if (a < 16'h8000) begin
        bank = (cfg_cart == CART_MBC1) ? ((bank_hi << 5) | bank_lo[4:0]) : bank_lo;
        res.action = ACT_ROM_RD;
        res.phys_address = 23'(((bank & mask) << 14) | (a - 16'h4000));
      end else if (a >= 16'hA000 && a <= 16'hBFFF) begin
        if (!ram_en || cfg_ram_bits == 0) res.action = ACT_OPEN;
        else begin
          res.action = ACT_RAM_RD;
          res.phys_address = ram_offset(a);
          res.force_high_nibble = (cfg_cart == CART_MBC2);
        end
      end
    end
    return res;
  endfunction

  // random access, weighted toward register writes and banked windows
  function automatic req_t pick_access();
    req_t r;
    int unsigned sel;
    r.req_type = REQ_RD;
    r.bus_address = 16'($urandom);
    r.write_value = 8'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      r.req_type = REQ_WR;
      r.bus_address[15] = 1'b0;
      if ($urandom_range(0, 3) == 0) r.write_value = 8'($urandom_range(0, 4));
      else if ($urandom_range(0, 2) == 0) r.write_value[3:0] = RAM_KEY;
    end else if (sel < 60) begin
      r.bus_address[15] = 1'b0;
    end else if (sel < 85) begin
      r.req_type = 1'($urandom);
      r.bus_address[15:13] = 3'b101;
    end else begin
      r.req_type = 1'($urandom);
    end
    return r;
  endfunction

  task automatic report_miss(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // send one access, predict its mapping, then maybe leave a gap
  task automatic issue(req_t r, logic use_lit, rsp_t lit);
    rsp_t want;
    int unsigned pick, gap;
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    want = map_access(r);
    if (use_lit) want = lit;
    pending_maps.insert(pending_maps.size(), want);
    accesses_sent++;
    gap = 0;
    if (!calm) begin
      pick = $urandom_range(0, 99);
      if (pick >= 95) gap = $urandom_range(8, 30);
      else if (pick >= 70) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    while (pending_maps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write followed by a read back of the same register
  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] val);
    logic [CfgDataW-1:0] rd;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rd = prdata;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== val) begin
      report_miss($sformatf("%s read back %h, wrote %h", idx.name(), rd, val));
    end
  endtask

  task automatic set_mapper(cfg_t c);
    in_valid_i <= 1'b0;
    wait_idle();
    write_reg(REG_CART_TYPE, CfgDataW'(c.cart_type));
    write_reg(REG_ROM_BANK_BITS, CfgDataW'(c.rom_bank_bits));
    write_reg(REG_RAM_ADDR_BITS, CfgDataW'(c.ram_addr_bits));
    cfg_cart = c.cart_type;
    cfg_rom_bits = c.rom_bank_bits;
    cfg_ram_bits = c.ram_addr_bits;
    settings_run++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      obs_got = out_data_o;
      if (pending_maps.size() == 0) begin
        report_miss($sformatf("result with nothing pending: act %0d phys %h",
                              obs_got.action, obs_got.phys_address));
      end else begin
        obs_want = pending_maps.pop_front();
        results_seen++;
        action_hits[obs_want.action]++;
        if (obs_got.action !== obs_want.action ||
            obs_got.phys_address !== obs_want.phys_address ||
            obs_got.mem_write_data !== obs_want.mem_write_data ||
            obs_got.force_high_nibble !== obs_want.force_high_nibble) begin
          report_miss($sformatf(
            "result %0d: want act %0d phys %h data %h hi %b, got act %0d phys %h data %h hi %b",
            results_seen, obs_want.action, obs_want.phys_address,
            obs_want.mem_write_data, obs_want.force_high_nibble, obs_got.action,
            obs_got.phys_address, obs_got.mem_write_data, obs_got.force_high_nibble));
        end
      end
    end
  end

  // receiver back-pressure: alternating free and stalled runs
  always @(posedge clk_i) begin
    if (!rst_ni || calm) begin
      out_stall_i <= 1'b0;
      stall_run <= 0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      stall_run <= $urandom_range(0, 8);
    end else begin
      out_stall_i <= 1'b1;
      stall_run <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(10, 40);
    end
  end

  // watchdog on cycles where no item moves
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results pending",
               quiet_cycles, pending_maps.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_t next_cfg;
    req_t r;
    directed_rows = '{
      // reset settings: no mapper, two rom banks, no ram
      lit_row(REQ_RD, 16'h0000, 8'h00, ACT_ROM_RD, 23'h000000),
      lit_row(REQ_RD, 16'h7FFF, 8'h00, ACT_ROM_RD, 23'h007FFF),
      lit_row(REQ_WR, 16'h0000, 8'h0A, ACT_DROP, 23'h0),
      lit_row(REQ_RD, 16'hBFFF, 8'h00, ACT_OPEN, 23'h0),
      lit_row(REQ_WR, 16'hA000, 8'hFF, ACT_DROP, 23'h0),
      lit_row(REQ_RD, 16'h8000, 8'h00, ACT_NONE, 23'h0),
      lit_row(REQ_WR, 16'hFFFF, 8'hFF, ACT_NONE, 23'h0),
      // mbc1: zero bank fixup, upper bits, mode 1
      cfg_row(CART_MBC1, 4'd9, 5'd15),
      lit_row(REQ_WR, 16'h1FFF, 8'h0A, ACT_REG_WR, 23'h0),
      lit_row(REQ_WR, 16'h2000, 8'h00, ACT_REG_WR, 23'h0),
      acc_row(REQ_WR, 16'h5FFF, 8'h03),
      acc_row(REQ_WR, 16'h7FFF, 8'h01),
      acc_row(REQ_RD, 16'h3FFF, 8'h00),
      acc_row(REQ_RD, 16'h4000, 8'h00),
      acc_row(REQ_WR, 16'hA000, 8'hFF),
      // mbc2: bit 8 selects the register, nibble ram
      cfg_row(CART_MBC2, 4'd4, 5'd9),
      acc_row(REQ_WR, 16'h0100, 8'h00),
      acc_row(REQ_WR, 16'h0000, 8'h0A),
      lit_row(REQ_WR, 16'h4100, 8'h05, ACT_REG_WR, 23'h0),
      acc_row(REQ_WR, 16'hA3FF, 8'hFF),
      acc_row(REQ_RD, 16'hBE01, 8'h00),
      // mbc3: ram bank above 3 ignored, largest ram
      cfg_row(CART_MBC3, 4'd7, 5'd17),
      acc_row(REQ_WR, 16'h4000, 8'h04),
      acc_row(REQ_WR, 16'h2000, 8'h80),
      acc_row(REQ_RD, 16'h7FFF, 8'h00),
      acc_row(REQ_RD, 16'hBFFF, 8'h00),
      // mbc5: ninth bank bit, oversized sizes clamp
      cfg_row(CART_MBC5, 4'd15, 5'd31),
      acc_row(REQ_WR, 16'h3000, 8'h01),
      acc_row(REQ_WR, 16'h2000, 8'hFF),
      acc_row(REQ_RD, 16'h7FFF, 8'h00),
      acc_row(REQ_WR, 16'h4000, 8'h0F),
      acc_row(REQ_WR, 16'hBFFF, 8'h5A),
      // unknown kind acts as no mapper, single rom bank
      cfg_row(CART_UNKNOWN, 4'd0, 5'd0),
      lit_row(REQ_WR, 16'h1000, 8'h0A, ACT_DROP, 23'h0),
      lit_row(REQ_RD, 16'h4000, 8'h00, ACT_ROM_RD, 23'h0)
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) set_mapper(directed_rows[i].cfg);
      else issue(directed_rows[i].req, directed_rows[i].has_lit, directed_rows[i].lit);
    end

    // random phases, fixed extremes first, then random settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: next_cfg = '{cart_type: CART_MBC1, rom_bank_bits: 4'd0, ram_addr_bits: 5'd17};
        1: next_cfg = '{cart_type: CART_MBC1, rom_bank_bits: 4'd9, ram_addr_bits: 5'd13};
        2: next_cfg = '{cart_type: CART_MBC2, rom_bank_bits: 4'd3, ram_addr_bits: 5'd1};
        3: next_cfg = '{cart_type: CART_MBC3, rom_bank_bits: 4'd7, ram_addr_bits: 5'd15};
        4: next_cfg = '{cart_type: CART_MBC5, rom_bank_bits: 4'd9, ram_addr_bits: 5'd17};
        5: next_cfg = '{cart_type: CART_MBC5, rom_bank_bits: 4'd15, ram_addr_bits: 5'd31};
        default: begin
          next_cfg.cart_type = 3'($urandom_range(0, 7));
          next_cfg.rom_bank_bits = 4'($urandom_range(0, 15));
          next_cfg.ram_addr_bits = 5'($urandom_range(0, 31));
        end
      endcase
      set_mapper(next_cfg);
      calm <= (ph == 3);
      // open ram first so the banked window gets real traffic
      r = '{req_type: REQ_WR, bus_address: 16'h0000, write_value: 8'h0A};
      issue(r, 1'b0, '0);
      for (int k = 1; k < ACCESSES_PER_PHASE; k++) issue(pick_access(), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    wait_idle();
    $display("ran %0d accesses under %0d mapper settings, %0d results checked",
             accesses_sent, settings_run, results_seen);
    $display("actions: none %0d rom %0d ram-rd %0d ram-wr %0d open %0d reg %0d drop %0d",
             action_hits[ACT_NONE], action_hits[ACT_ROM_RD], action_hits[ACT_RAM_RD],
             action_hits[ACT_RAM_WR], action_hits[ACT_OPEN], action_hits[ACT_REG_WR],
             action_hits[ACT_DROP]);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hdl/cbm_pkg.sv
hdl/cbm_cfg.sv
hdl/cbm_map.sv
hdl/cartridge_bank_mapper_top.sv
test/cartridge_bank_mapper_top_test.sv
